// ===== rtl/core/bsd_pkg.sv =====
// Package for the BMP stream decoder: parser state, result record and header constants.
// Used by every module under rtl/core; has no dependencies of its own.
package bsd_pkg;

    // Image size limits accepted from the info header.
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Fixed widths of the result fields.
    localparam int CHAN_W  = 8;
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;

    // Header layout, as byte positions within the file.
    localparam logic [7:0]  SIG_B         = 8'h42;
    localparam logic [7:0]  SIG_M         = 8'h4D;
    localparam logic [31:0] POS_SIG_B     = 32'd0;
    localparam logic [31:0] POS_SIG_M     = 32'd1;
    localparam logic [31:0] POS_OFFSET_LO = 32'd10;
    localparam logic [31:0] POS_OFFSET_HI = 32'd13;
    localparam logic [31:0] POS_WIDTH_LO  = 32'd18;
    localparam logic [31:0] POS_WIDTH_HI  = 32'd21;
    localparam logic [31:0] POS_HEIGHT_LO = 32'd22;
    localparam logic [31:0] POS_HEIGHT_HI = 32'd25;
    localparam logic [31:0] POS_BPP       = 32'd28;
    localparam logic [31:0] HEADER_BYTES  = 32'd54;
    localparam logic [31:0] HEADER_LAST   = 32'd53;
    localparam logic [7:0]  BPP_ALPHA     = 8'd32;

    // Result kinds carried on the output tuser.
    typedef enum logic [1:0] {
        KIND_PIXEL   = 2'd0,
        KIND_BAD_SIG = 2'd1,
        KIND_BAD_HDR = 2'd2
    } kind_t;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_HEADER = 3'd1,
        PH_SKIP   = 3'd2,
        PH_PIXEL  = 3'd3,
        PH_PAD    = 3'd4
    } phase_t;

    // Complete parser state.
    typedef struct packed {
        phase_t               phase;
        logic [31:0]          byte_pos;
        logic [31:0]          data_offset;
        logic [31:0]          width;
        logic [31:0]          height;
        logic [7:0]           bits;
        logic [23:0]          pixel;
        logic [1:0]           chan;
        logic [COORD_W-1:0]   col;
        logic [COORD_W-1:0]   row;
        logic [1:0]           pad;
    } pstate_t;

    // One result item.
    typedef struct packed {
        kind_t                kind;
        logic [CHAN_W-1:0]    red;
        logic [CHAN_W-1:0]    green;
        logic [CHAN_W-1:0]    blue;
        logic [CHAN_W-1:0]    alpha;
        logic [COORD_W-1:0]   column;
        logic [COORD_W-1:0]   row;
        logic                 last_pixel;
        logic [DIM_W-1:0]     image_width;
        logic [DIM_W-1:0]     image_height;
        logic                 has_alpha;
    } res_t;

endpackage

// ===== rtl/core/bsd_parser.sv =====
// Byte parser of the BMP stream decoder: header capture, offset skip, pixel assembly.
// Depends on bsd_pkg. The result it forms is registered by bsd_out_buf.
module bsd_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic [7:0]     data_byte,
    input  logic           sof,
    output logic           res_valid,
    output bsd_pkg::res_t  res
);
    import bsd_pkg::*;

    pstate_t     state_reg;
    pstate_t     state_next;
    pstate_t     cur;
    pstate_t     nxt;
    logic        alpha_on;
    logic [1:0]  lane;
    logic [1:0]  final_chan;
    logic [23:0] pix;
    logic [12:0] col_inc;
    logic [12:0] row_inc;
    logic        last;
    logic        hdr_bad;

    // State register; the all-zero state is the waiting phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // One byte of work: next state and the result it causes.
    always_comb
    begin
        cur = state_reg;
        if (sof)
        begin
            cur       = '0;
            cur.phase = PH_HEADER;
        end
        nxt        = cur;
        res        = '0;
        res_valid  = 1'b0;
        alpha_on   = (cur.bits == BPP_ALPHA);
        final_chan = alpha_on ? 2'd3 : 2'd2;
        // Little-endian fields start at positions that are 2 modulo 4.
        lane       = cur.byte_pos[1:0] - 2'd2;
        pix        = cur.pixel;
        col_inc    = {1'b0, cur.col} + 13'd1;
        row_inc    = {1'b0, cur.row} + 13'd1;
        last       = (col_inc == cur.width[12:0]) && (row_inc == cur.height[12:0]);
        hdr_bad    = 1'b0;

        unique case (cur.phase)
            PH_HEADER:
            begin
                if ((cur.byte_pos == POS_SIG_B && data_byte != SIG_B) ||
                    (cur.byte_pos == POS_SIG_M && data_byte != SIG_M))
                begin
                    res_valid = 1'b1;
                    res.kind  = KIND_BAD_SIG;
                    nxt.phase = PH_WAIT;
                end
                else
                begin
                    if (cur.byte_pos >= POS_OFFSET_LO && cur.byte_pos <= POS_OFFSET_HI)
                        nxt.data_offset[{lane, 3'b000} +: 8] = data_byte;
                    else if (cur.byte_pos >= POS_WIDTH_LO && cur.byte_pos <= POS_WIDTH_HI)
                        nxt.width[{lane, 3'b000} +: 8] = data_byte;
                    else if (cur.byte_pos >= POS_HEIGHT_LO && cur.byte_pos <= POS_HEIGHT_HI)
                        nxt.height[{lane, 3'b000} +: 8] = data_byte;
                    else if (cur.byte_pos == POS_BPP)
                        nxt.bits = data_byte;
                    nxt.byte_pos = cur.byte_pos + 32'd1;

                    // Validate the header on its final byte.
                    if (cur.byte_pos == HEADER_LAST)
                    begin
                        hdr_bad = (nxt.data_offset < HEADER_BYTES) ||
                                  (nxt.width == 32'd0) ||
                                  (nxt.width > 32'(MAX_WIDTH)) ||
                                  (nxt.height == 32'd0) ||
                                  (nxt.height > 32'(MAX_HEIGHT));
                        if (hdr_bad)
                        begin
                            res_valid = 1'b1;
                            res.kind  = KIND_BAD_HDR;
                            nxt.phase = PH_WAIT;
                        end
                        else if (nxt.data_offset == HEADER_BYTES)
                            nxt.phase = PH_PIXEL;
                        else
                            nxt.phase = PH_SKIP;
                    end
                end
            end

            PH_SKIP:
            begin
                nxt.byte_pos = cur.byte_pos + 32'd1;
                if (nxt.byte_pos == cur.data_offset)
                    nxt.phase = PH_PIXEL;
            end

            PH_PIXEL:
            begin
                // The alpha byte is not stored; it goes straight to the result.
                if (cur.chan != 2'd3)
                    pix[{cur.chan, 3'b000} +: 8] = data_byte;
                if (cur.chan != final_chan)
                begin
                    nxt.chan  = cur.chan + 2'd1;
                    nxt.pixel = pix;
                end
                else
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_PIXEL;
                    res.red          = pix[23:16];
                    res.green        = pix[15:8];
                    res.blue         = pix[7:0];
                    res.alpha        = alpha_on ? data_byte : '0;
                    res.column       = cur.col;
                    res.row          = cur.row;
                    res.last_pixel   = last;
                    res.image_width  = cur.width[DIM_W-1:0];
                    res.image_height = cur.height[DIM_W-1:0];
                    res.has_alpha    = alpha_on;
                    nxt.pixel        = '0;
                    nxt.chan         = 2'd0;
                    if (last)
                        nxt.phase = PH_WAIT;
                    else if (col_inc == cur.width[12:0])
                    begin
                        // End of row; 24-bit rows pad to a multiple of four bytes.
                        nxt.col = '0;
                        nxt.row = row_inc[COORD_W-1:0];
                        nxt.pad = alpha_on ? 2'd0 : cur.width[1:0];
                        if (!alpha_on && cur.width[1:0] != 2'd0)
                            nxt.phase = PH_PAD;
                    end
                    else
                    begin
                        nxt.col = col_inc[COORD_W-1:0];
                    end
                end
            end

            PH_PAD:
            begin
                if (cur.pad != 2'd0)
                    nxt.pad = cur.pad - 2'd1;
                if (nxt.pad == 2'd0)
                    nxt.phase = PH_PIXEL;
            end

            default:
            begin
                nxt = cur;
            end
        endcase

        state_next = advance ? nxt : state_reg;
    end

    // The header counter never runs past the header.
    a_header_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_HEADER |-> state_reg.byte_pos < HEADER_BYTES)
        else $error("header byte position past header end");

    // Padding phase always has bytes left to drop.
    a_pad_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_PAD |-> state_reg.pad != 2'd0)
        else $error("padding phase with no padding left");

    // Pixel coordinates stay inside the validated image.
    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_PIXEL || state_reg.phase == PH_PAD) |->
        ({1'b0, state_reg.col} < state_reg.width[12:0] &&
         {1'b0, state_reg.row} < state_reg.height[12:0]))
        else $error("pixel coordinate outside image");

    // Any error result leaves the parser waiting for a new file.
    a_error_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_valid && res.kind != KIND_PIXEL) |=> state_reg.phase == PH_WAIT)
        else $error("parser did not stop after an error");

endmodule

// ===== rtl/core/bsd_out_buf.sv =====
// Result register with a skid entry for the BMP stream decoder output.
// Depends on bsd_pkg; ready toward the parser comes straight from a register.
module bsd_out_buf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bsd_pkg::res_t  push_data,
    output logic           ready,
    output logic           out_valid,
    input  logic           out_ready,
    output bsd_pkg::res_t  out_data
);
    import bsd_pkg::*;

    logic main_vld_reg;
    logic main_vld_next;
    logic skid_vld_reg;
    logic skid_vld_next;
    logic main_free;
    res_t main_reg;
    res_t skid_reg;

    assign main_free = !main_vld_reg || out_ready;
    assign ready     = !skid_vld_reg;
    assign out_valid = main_vld_reg;
    assign out_data  = main_reg;

    // Valid flags: the skid entry drains first whenever the main register frees.
    always_comb
    begin
        main_vld_next = main_vld_reg;
        skid_vld_next = skid_vld_reg;
        if (main_free)
        begin
            main_vld_next = skid_vld_reg || push;
            skid_vld_next = 1'b0;
        end
        else if (push)
        begin
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            main_vld_reg <= main_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            if (skid_vld_reg)
                main_reg <= skid_reg;
            else if (push)
                main_reg <= push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

// ===== rtl/core/bmp_stream_decoder_top.sv =====
// Top level of the BMP stream decoder: input register, byte parser and output buffer.
// Depends on bsd_pkg, bsd_parser and bsd_out_buf.

// The decoder takes a BMP file one byte per request, with s_tuser set on the first
// byte, and returns one pixel request per 24- or 32-bit pixel in file order, or a
// single error request for a bad signature or an unusable header. It sustains one
// byte per clock while the output buffer has room; each byte passes an input
// register, the combinational parser logic and a result register.
// Stalls on m_tready back up into s_tready only once the two-entry output buffer
// is full. There is no clearing pass after reset.
module bmp_stream_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [43:32] column,
    // [55:44] row, [68:56] image_width, [81:69] image_height, [82] has_alpha,
    // [87:83] zero
    output logic [87:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last_pixel
);
    import bsd_pkg::*;

    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] in_data_reg;
    logic       in_sof_reg;
    logic       s_accept;
    logic       advance;
    logic       buf_ready;
    logic       res_valid;
    res_t       res;
    res_t       out_res;

    // Input register stage.
    assign s_tready    = !in_vld_reg || buf_ready;
    assign s_accept    = s_tvalid && s_tready;
    assign advance     = in_vld_reg && buf_ready;
    assign in_vld_next = s_accept || (in_vld_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_data_reg <= s_tdata;
            in_sof_reg  <= s_tuser;
        end
    end

    bsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (in_data_reg),
        .sof       (in_sof_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    bsd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance && res_valid),
        .push_data (res),
        .ready     (buf_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Output packing.
    assign m_tdata = {5'b00000, out_res.has_alpha, out_res.image_height,
                      out_res.image_width, out_res.row, out_res.column,
                      out_res.alpha, out_res.blue, out_res.green, out_res.red};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last_pixel;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for bmp_stream_decoder_top: streams BMP files of many shapes, some
// broken, and checks every pixel or error request against a byte-level decoder model.
// Depends on bsd_pkg and the decoder RTL under rtl/core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bsd_pkg::*;

    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         ITEM_TARGET    = 1250;
    localparam int         TAIL_ITEMS     = 200;
    localparam int         LONG_STALL     = 300;
    localparam int         DRAIN_CYCLES   = 20;
    localparam logic [7:0] BPP_TRUE_COLOR = 8'd24;

    // Shapes of file that the stimulus builds.
    typedef enum int {
        ST_GOOD,
        ST_SIG0,
        ST_SIG1,
        ST_LOW_OFFSET,
        ST_ZERO_W,
        ST_BIG_W,
        ST_ZERO_H,
        ST_BIG_H,
        ST_NEG_H,
        ST_MAX_DIM,
        ST_FAR_OFFSET,
        ST_CUT_HEADER,
        ST_CUT_PIXELS,
        ST_COUNT
    } file_style_t;

    // Decoder model and the queue of results it expects from the block.
    class bmp_decode_board;
        phase_t      stage;
        logic [31:0] hdr_pos;
        logic [31:0] pix_offset;
        logic [31:0] img_w;
        logic [31:0] img_h;
        logic [31:0] col_at;
        logic [31:0] row_at;
        logic [7:0]  bpp;
        logic [23:0] bgr_acc;
        logic [1:0]  chan_at;
        logic [1:0]  pad_left;
        res_t        expected_q[$];
        int          mismatches;
        int          pixels_seen;
        int          sig_errors;
        int          hdr_errors;
        int          bytes_taken;

        function new();
            restart();
            mismatches  = 0;
            pixels_seen = 0;
            sig_errors  = 0;
            hdr_errors  = 0;
            bytes_taken = 0;
        endfunction

        function void restart();
            stage      = PH_WAIT;
            hdr_pos    = '0;
            pix_offset = '0;
            img_w      = '0;
            img_h      = '0;
            col_at     = '0;
            row_at     = '0;
            bpp        = '0;
            bgr_acc    = '0;
            chan_at    = '0;
            pad_left   = '0;
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 30)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        // Advance the model by one accepted byte and queue the result it causes.
        function void decode_byte(logic [7:0] b, logic sof);
            res_t        r;
            logic [31:0] at;
            bit          alpha_on;
            bit          fin;
            bit          emit;
            r = '0;
            emit = 1'b0;
            bytes_taken++;
            if (sof)
            begin
                restart();
                stage = PH_HEADER;
            end
            at = hdr_pos;
            alpha_on = (bpp == BPP_ALPHA);
            case (stage)
                PH_HEADER:
                begin
                    if ((at == POS_SIG_B && b != SIG_B) || (at == POS_SIG_M && b != SIG_M))
                    begin
                        r.kind = KIND_BAD_SIG;
                        emit = 1'b1;
                        stage = PH_WAIT;
                        sig_errors++;
                    end
                    else
                    begin
                        if (at >= POS_OFFSET_LO && at <= POS_OFFSET_HI)
                            pix_offset |= 32'(b) << (8 * (at - POS_OFFSET_LO));
                        else if (at >= POS_WIDTH_LO && at <= POS_WIDTH_HI)
                            img_w |= 32'(b) << (8 * (at - POS_WIDTH_LO));
                        else if (at >= POS_HEIGHT_LO && at <= POS_HEIGHT_HI)
                            img_h |= 32'(b) << (8 * (at - POS_HEIGHT_LO));
                        else if (at == POS_BPP)
                            bpp = b;
                        hdr_pos = at + 1;
                        if (at == HEADER_LAST)
                        begin
                            // Heights are unsigned here, so top-down images fail too.
                            if (pix_offset < HEADER_BYTES || img_w == 0 ||
                                img_w > 32'(MAX_WIDTH) || img_h == 0 ||
                                img_h > 32'(MAX_HEIGHT))
                            begin
                                r.kind = KIND_BAD_HDR;
                                emit = 1'b1;
                                stage = PH_WAIT;
                                hdr_errors++;
                            end
                            else
                                stage = (pix_offset == HEADER_BYTES) ? PH_PIXEL : PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    hdr_pos = hdr_pos + 1;
                    if (hdr_pos == pix_offset)
                        stage = PH_PIXEL;
                end
                PH_PIXEL:
                begin
                    if (chan_at < 2'd3)
                        bgr_acc |= 24'(b) << (8 * chan_at);
                    if (chan_at < (alpha_on ? 2'd3 : 2'd2))
                        chan_at = chan_at + 1;
                    else
                    begin
                        fin = (col_at + 1 == img_w) && (row_at + 1 == img_h);
                        r.kind         = KIND_PIXEL;
                        r.red          = bgr_acc[23:16];
                        r.green        = bgr_acc[15:8];
                        r.blue         = bgr_acc[7:0];
                        r.alpha        = alpha_on ? b : 8'h00;
                        r.column       = col_at[COORD_W-1:0];
                        r.row          = row_at[COORD_W-1:0];
                        r.last_pixel   = fin;
                        r.image_width  = img_w[DIM_W-1:0];
                        r.image_height = img_h[DIM_W-1:0];
                        r.has_alpha    = alpha_on;
                        emit = 1'b1;
                        pixels_seen++;
                        bgr_acc = '0;
                        chan_at = '0;
                        if (fin)
                            stage = PH_WAIT;
                        else
                        begin
                            col_at = col_at + 1;
                            if (col_at == img_w)
                            begin
                                // End of row: 24-bit rows are padded to a multiple of 4 bytes.
                                col_at = '0;
                                row_at = row_at + 1;
                                pad_left = alpha_on ? 2'd0 : 2'((4 - ((img_w * 3) & 3)) & 3);
                                if (pad_left != 0)
                                    stage = PH_PAD;
                            end
                        end
                    end
                end
                PH_PAD:
                begin
                    if (pad_left > 0)
                        pad_left = pad_left - 1;
                    if (pad_left == 0)
                        stage = PH_PIXEL;
                end
                default:
                    ;
            endcase
            if (emit)
                expected_q.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] seen, logic [31:0] want);
            if (seen !== want)
                report($sformatf("%s is 0x%0h, expected 0x%0h", name, seen, want));
        endfunction

        // Compare one accepted output request with the oldest expected result.
        function void compare_output(kind_t k, logic [87:0] d, logic last);
            res_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result of kind %0d", k));
                return;
            end
            want = expected_q.pop_front();
            check_field("kind", 32'(k), 32'(want.kind));
            check_field("red", 32'(d[7:0]), 32'(want.red));
            check_field("green", 32'(d[15:8]), 32'(want.green));
            check_field("blue", 32'(d[23:16]), 32'(want.blue));
            check_field("alpha", 32'(d[31:24]), 32'(want.alpha));
            check_field("column", 32'(d[43:32]), 32'(want.column));
            check_field("row", 32'(d[55:44]), 32'(want.row));
            check_field("image_width", 32'(d[68:56]), 32'(want.image_width));
            check_field("image_height", 32'(d[81:69]), 32'(want.image_height));
            check_field("has_alpha", 32'(d[82]), 32'(want.has_alpha));
            check_field("tdata fill", 32'(d[87:83]), 32'd0);
            check_field("last_pixel", 32'(last), 32'(want.last_pixel));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    bmp_decode_board board;
    int              items_sent = 0;
    int              files_sent = 0;
    int              src_gap_pct = 0;
    int              cycle_count = 0;
    bit              steady_tail = 1'b0;
    bit              stall_request = 1'b0;

    bmp_stream_decoder_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Check every output request taken at this edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.compare_output(kind_t'(m_tuser), m_tdata, m_tlast);
    end

    // Output back-pressure: random short holds, one long hold on request, none at the end.
    initial
    begin : sink_side
        int k;
        int sink_gap_pct;
        sink_gap_pct = 10;
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                m_tready <= 1'b0;
                for (k = 1; k < LONG_STALL; k++)
                    @(posedge clk);
            end
            else if (!steady_tail && $urandom_range(0, 99) < sink_gap_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
            if ($urandom_range(0, 63) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: sink_gap_pct = 0;
                    1: sink_gap_pct = 10;
                    default: sink_gap_pct = 35;
                endcase
            end
        end
    end

    // Offer one byte, possibly after a short gap, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic sof);
        if (!steady_tail && src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        board.decode_byte(b, sof);
        items_sent++;
        if (items_sent >= ITEM_TARGET - TAIL_ITEMS)
            steady_tail = 1'b1;
    endtask

    // Stop offering and wait until every expected result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Build one file from its header values and stream it, optionally truncated.
    task automatic send_image(input logic [31:0] w, input logic [31:0] h,
                              input logic [31:0] offs, input logic [7:0] bpp,
                              input logic [7:0] sig0, input logic [7:0] sig1,
                              input int cut_at, input int tail, input bit hold_here);
        logic [7:0] img[$];
        int         n;
        int         k;
        int         p;
        int         cap;
        int         bpx;
        int         pad;
        int         total;
        bit         hdr_ok;
        img = {};
        cap = (cut_at >= 0) ? cut_at : 32'h7FFF_FFFF;
        for (n = 0; n < int'(HEADER_BYTES); n++)
            img.push_back(8'($urandom));
        img[POS_SIG_B] = sig0;
        img[POS_SIG_M] = sig1;
        img[14] = 8'd40;
        img[POS_BPP] = bpp;
        for (n = 0; n < 4; n++)
        begin
            img[POS_OFFSET_LO + n] = offs[8*n +: 8];
            img[POS_WIDTH_LO + n]  = w[8*n +: 8];
            img[POS_HEIGHT_LO + n] = h[8*n +: 8];
        end
        hdr_ok = sig0 == SIG_B && sig1 == SIG_M && offs >= HEADER_BYTES && w != 0 &&
                 w <= 32'(MAX_WIDTH) && h != 0 && h <= 32'(MAX_HEIGHT);
        if (hdr_ok)
        begin
            // Gap up to the pixel data, then pixels with row padding.
            for (n = int'(HEADER_BYTES); n < int'(HEADER_BYTES) + 64 && n < offs; n++)
                img.push_back(8'($urandom));
            bpx = (bpp == BPP_ALPHA) ? 4 : 3;
            pad = (bpp == BPP_ALPHA) ? 0 : (4 - ((int'(w) * 3) & 3)) & 3;
            total = int'(w) * int'(h);
            p = 0;
            while (p < total && img.size() < cap)
            begin
                for (k = 0; k < bpx; k++)
                begin
                    case ($urandom_range(0, 3))
                        0: img.push_back(8'h00);
                        1: img.push_back(8'hFF);
                        default: img.push_back(8'($urandom));
                    endcase
                end
                p++;
                if (p % int'(w) == 0)
                    for (k = 0; k < pad; k++)
                        img.push_back(8'($urandom));
            end
        end
        for (n = 0; n < tail; n++)
            img.push_back(8'($urandom));
        while (img.size() > cap)
            void'(img.pop_back());
        files_sent++;
        for (n = 0; n < img.size(); n++)
        begin
            if (hold_here && n == int'(HEADER_BYTES))
                stall_request = 1'b1;
            send_byte(img[n], n == 0);
        end
    endtask

    // Pick header values for one shape of file and send it.
    task automatic send_style(input file_style_t st, input bit hold_here);
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] offs;
        logic [7:0]  bpp;
        logic [7:0]  s0;
        logic [7:0]  s1;
        int          cut;
        int          tail;
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 4);
        if ($urandom_range(0, 7) == 0)
        begin
            w = $urandom_range(9, 40);
            h = $urandom_range(1, 2);
        end
        offs = HEADER_BYTES + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
        case ($urandom_range(0, 4))
            0, 1: bpp = BPP_TRUE_COLOR;
            2, 3: bpp = BPP_ALPHA;
            default: bpp = 8'($urandom);
        endcase
        s0 = SIG_B;
        s1 = SIG_M;
        cut = -1;
        tail = $urandom_range(0, 3);
        case (st)
            ST_SIG0:
                do s0 = 8'($urandom); while (s0 == SIG_B);
            ST_SIG1:
                do s1 = 8'($urandom); while (s1 == SIG_M);
            ST_LOW_OFFSET:
                offs = $urandom_range(0, 1) ? HEADER_LAST : $urandom_range(0, 53);
            ST_ZERO_W:
                w = 0;
            ST_BIG_W:
                w = $urandom_range(0, 1) ? 32'(MAX_WIDTH) + 1 : ($urandom | 32'h0000_2000);
            ST_ZERO_H:
                h = 0;
            ST_BIG_H:
                h = $urandom_range(0, 1) ? 32'(MAX_HEIGHT) + 1 : ($urandom | 32'h0000_2000);
            ST_NEG_H:
                h = 32'hFFFF_FFFF - $urandom_range(0, 15);
            ST_MAX_DIM:
            begin
                w = MAX_WIDTH;
                h = MAX_HEIGHT;
                cut = int'(offs) + $urandom_range(4, 40);
            end
            ST_FAR_OFFSET:
            begin
                offs = $urandom | 32'h8000_0000;
                cut = int'(HEADER_BYTES) + $urandom_range(0, 30);
            end
            ST_CUT_HEADER:
                cut = $urandom_range(2, 53);
            ST_CUT_PIXELS:
            begin
                w = $urandom_range(2, 8);
                h = $urandom_range(2, 4);
                cut = int'(offs) + $urandom_range(1, 20);
            end
            default:
                ;
        endcase
        // The long output hold needs an 8 by 4 image of 32-bit pixels behind it.
        if (hold_here)
        begin
            w = 8;
            h = 4;
            offs = HEADER_BYTES;
            bpp = BPP_ALPHA;
        end
        src_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
        send_image(w, h, offs, bpp, s0, s1, cut, tail, hold_here);
    endtask

    // Reset, directed bytes, one file of each shape, then random files until the byte budget is spent.
    initial
    begin : stimulus
        int          fidx;
        file_style_t st;
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Bytes before any start of file are ignored.
        src_gap_pct = 20;
        send_byte(SIG_B, 1'b0);
        send_byte(SIG_M, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        // Bad signature on the first byte and on the second byte.
        send_byte(8'h00, 1'b1);
        send_byte(SIG_B, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(SIG_M, 1'b1);
        // Bytes after an error wait for a new file.
        send_byte(SIG_B, 1'b0);
        // Restart in the middle of a header, then fail on the new second byte.
        send_byte(SIG_B, 1'b1);
        send_byte(SIG_M, 1'b0);
        send_byte(SIG_B, 1'b1);
        send_byte(SIG_B, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain_results();

        fidx = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (fidx < int'(ST_COUNT))
                st = file_style_t'(fidx);
            else if ($urandom_range(0, 99) < 70)
                st = ST_GOOD;
            else
                st = file_style_t'($urandom_range(1, int'(ST_COUNT) - 1));
            if (fidx == int'(ST_COUNT) + 3)
                drain_results();
            send_style(st, fidx == 0);
            fidx++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d files in %0d bytes: %0d pixels, %0d bad signatures, %0d bad headers",
                 files_sent, board.bytes_taken, board.pixels_seen, board.sig_errors,
                 board.hdr_errors);
        $display("including truncated and restarted files and one %0d-cycle output stall",
                 LONG_STALL);
        if (board.mismatches == 0 && board.expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
